### sv/lgsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the light gun sensor port.
package lgsp_pkg;

	localparam int PALETTE_ENTRIES_DEF = 64;

	localparam int TYPE_W   = 2;
	localparam int LINE_W   = 9;
	localparam int COL_W    = 8;
	localparam int COLOR_W  = 6;
	localparam int CYCLE_W  = 16;
	localparam int PTR_W    = 9;
	localparam int BYTE_W   = 8;
	localparam int BRIGHT_W = 10;
	localparam int WINDOW_W = 8;
	localparam int HOLD_W   = 3;
	localparam int TIME_W   = 17;
	localparam int THIRD_W  = 7;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [TYPE_W-1:0] {
		REQ_PIXEL    = 2'd0,
		REQ_POINTER  = 2'd1,
		REQ_READ     = 2'd2,
		REQ_PAL_LOAD = 2'd3
	} req_type_t;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

	localparam logic [BRIGHT_W-1:0] THRESHOLD_RST = 10'd300;
	localparam logic [WINDOW_W-1:0] WINDOW_RST    = 8'd10;
	localparam logic [HOLD_W-1:0]   HOLD_RST      = 3'd5;

	localparam logic [PTR_W-1:0]  Y_OFF_SCREEN  = 9'd240;
	localparam logic [PTR_W-1:0]  ROW_REACH     = 9'd3;
	localparam logic [COL_W+1:0]  COL_LEFT      = 10'd4;
	localparam logic [COL_W+1:0]  COL_RIGHT     = 10'd3;
	localparam logic [TIME_W-1:0] FRAME_TIME    = 17'h10000;

	// x/3 for x below 256 as (x * 171) >> 9, exact over that range
	localparam logic [COL_W-1:0] DIV3_MUL   = 8'd171;
	localparam int               DIV3_SHIFT = 9;

	localparam int HOLD_BIT     = 4;
	localparam int NO_LIGHT_BIT = 3;

	typedef struct packed {
		logic [PTR_W-1:0] x;
		logic [PTR_W-1:0] y;
	} aim_t;

endpackage

### sv/lgsp_req_if.sv
`timescale 1ns / 1ps
// Request channel of the light gun sensor port.
interface lgsp_req_if;
	logic                         valid;
	logic                         ready;
	logic [lgsp_pkg::TYPE_W-1:0]   req_type;
	logic [lgsp_pkg::LINE_W-1:0]   line_number;
	logic                         line_start;
	logic [lgsp_pkg::COL_W-1:0]    pixel_column;
	logic [lgsp_pkg::COLOR_W-1:0]  pixel_color;
	logic [lgsp_pkg::CYCLE_W-1:0]  cycle_time;
	logic [lgsp_pkg::PTR_W-1:0]    pointer_x;
	logic [lgsp_pkg::PTR_W-1:0]    pointer_y;
	logic                         trigger;
	logic                         port_select;
	logic [lgsp_pkg::BYTE_W-1:0]   port_value_in;
	logic [lgsp_pkg::BRIGHT_W-1:0] brightness_sum;

	modport source (
		output valid, req_type, line_number, line_start, pixel_column, pixel_color,
		output cycle_time, pointer_x, pointer_y, trigger, port_select, port_value_in,
		output brightness_sum,
		input ready
	);
	modport sink (
		input valid, req_type, line_number, line_start, pixel_column, pixel_color,
		input cycle_time, pointer_x, pointer_y, trigger, port_select, port_value_in,
		input brightness_sum,
		output ready
	);
endinterface

### sv/lgsp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the light gun sensor port.
interface lgsp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [lgsp_pkg::BYTE_W-1:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

### sv/light_gun_sensor_port.sv
`timescale 1ns / 1ps
// Top level of the light gun sensor port: staging, state, palette memory, port byte.
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+--------------------------------------------
//  req      | in  | valid/ready   | pixel, pointer update, port read, palette load
//  rsp      | out | valid/ready   | read_data, one per port read
//  cfg      | in  | cfg_wen       | threshold, light window, trigger hold
//
// A port read reaches the response through the stage 1 register, which holds the
// registered palette read, and then the output register that takes the judgement.
// A new request is accepted every cycle; the stage stalls only while a port
// read waits behind an unaccepted response. Reset clears control and aim state;
// the palette holds no reset and must be loaded before pixels index it.
module light_gun_sensor_port #(
	parameter int PALETTE_ENTRIES = lgsp_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lgsp_req_if.sink                          req,
	lgsp_rsp_if.source                        rsp,
	input  logic                              cfg_wen,
	input  logic [lgsp_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lgsp_pkg::BRIGHT_W-1:0]     cfg_data
);
	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// configuration
	logic [lgsp_pkg::BRIGHT_W-1:0] threshold_q;
	logic [lgsp_pkg::WINDOW_W-1:0] window_q;
	logic [lgsp_pkg::HOLD_W-1:0]   hold_cfg_q;

	// palette
	logic [lgsp_pkg::BRIGHT_W-1:0] pal_mem [PALETTE_ENTRIES];
	logic [lgsp_pkg::PTR_W-1:0]    idx_ext;
	logic                          idx_ok;
	logic [AW-1:0]                 pal_addr;

	// stage 1
	logic                          v_s1;
	lgsp_pkg::req_type_t           type_s1;
	logic [lgsp_pkg::LINE_W-1:0]   line_s1;
	logic                          start_s1;
	logic [lgsp_pkg::COL_W-1:0]    col_s1;
	logic [lgsp_pkg::CYCLE_W-1:0]  t_s1;
	logic [lgsp_pkg::PTR_W-1:0]    px_s1;
	logic [lgsp_pkg::PTR_W-1:0]    py_s1;
	logic                          trig_s1;
	logic                          psel_s1;
	logic [lgsp_pkg::BYTE_W-1:0]   pval_s1;
	logic                          in_range_s1;
	logic [lgsp_pkg::BRIGHT_W-1:0] pal_rd_s1;

	// block state
	lgsp_pkg::aim_t                aim_q;
	logic [lgsp_pkg::THIRD_W-1:0]  aim_third_q;
	logic                          button_q;
	logic [lgsp_pkg::HOLD_W-1:0]   hold_q;
	logic [lgsp_pkg::TIME_W-1:0]   lt_q;
	logic [lgsp_pkg::TIME_W-1:0]   lt_prev_q;
	logic                          line_hit_q;

	// output register
	logic                          out_v_q;
	logic [lgsp_pkg::BYTE_W-1:0]   out_data_q;

	logic                          accept;
	logic                          adv;
	logic                          fire;
	logic                          lit;
	logic                          hit_eff;
	logic [lgsp_pkg::TIME_W-1:0]   lt_base;
	logic [2*lgsp_pkg::COL_W-1:0]  third_prod;
	logic [lgsp_pkg::HOLD_W-1:0]   hold_dec;
	logic                          in_cur;
	logic                          in_prev;
	logic [lgsp_pkg::BYTE_W-1:0]   read_byte;

	// ---------------- handshake ----------------
	assign adv       = !v_s1 || (type_s1 != lgsp_pkg::REQ_READ) || !out_v_q || rsp.ready;
	assign req.ready = adv;
	assign accept    = req.valid && adv;
	assign fire      = v_s1 && adv;

	assign rsp.valid     = out_v_q;
	assign rsp.read_data = out_data_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= lgsp_pkg::THRESHOLD_RST;
			window_q    <= lgsp_pkg::WINDOW_RST;
			hold_cfg_q  <= lgsp_pkg::HOLD_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				lgsp_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				lgsp_pkg::CFG_WINDOW:    window_q    <= cfg_data[lgsp_pkg::WINDOW_W-1:0];
				lgsp_pkg::CFG_HOLD:      hold_cfg_q  <= cfg_data[lgsp_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- palette memory ----------------
	assign idx_ext  = {{(lgsp_pkg::PTR_W-lgsp_pkg::COLOR_W){1'b0}}, req.pixel_color};
	assign idx_ok   = idx_ext < lgsp_pkg::PTR_W'(PALETTE_ENTRIES);
	assign pal_addr = idx_ext[AW-1:0];

	// loads write at acceptance, pixels read at acceptance: request order holds
	always_ff @(posedge clk) begin
		if (accept && req.req_type == lgsp_pkg::REQ_PAL_LOAD && idx_ok) begin
			pal_mem[pal_addr] <= req.brightness_sum;
		end
		if (accept) begin
			pal_rd_s1 <= pal_mem[pal_addr];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1     <= lgsp_pkg::req_type_t'(req.req_type);
			line_s1     <= req.line_number;
			start_s1    <= req.line_start;
			col_s1      <= req.pixel_column;
			t_s1        <= req.cycle_time;
			px_s1       <= req.pointer_x;
			py_s1       <= req.pointer_y;
			trig_s1     <= req.trigger;
			psel_s1     <= req.port_select;
			pval_s1     <= req.port_value_in;
			in_range_s1 <= idx_ok;
		end
	end

	lgsp_pixel_judge u_judge (
		.aim          (aim_q),
		.line_number  (line_s1),
		.pixel_column (col_s1),
		.brightness   (pal_rd_s1),
		.in_range     (in_range_s1),
		.threshold    (threshold_q),
		.lit          (lit)
	);

	// line start restarts the per-line record; line 0 parks the time past the frame
	assign hit_eff = start_s1 ? 1'b0 : line_hit_q;
	assign lt_base = (start_s1 && line_s1 == '0) ? lgsp_pkg::FRAME_TIME : lt_q;

	assign third_prod = px_s1[lgsp_pkg::COL_W-1:0] * lgsp_pkg::DIV3_MUL;
	assign hold_dec   = (hold_q != '0) ? hold_q - 1'b1 : hold_q;

	// ---------------- port byte ----------------
	always_comb begin
		in_cur  = ({1'b0, t_s1} >= lt_q) &&
		          ({2'b00, t_s1} <= {1'b0, lt_q} + {10'd0, window_q});
		in_prev = ({1'b0, t_s1} >= lt_prev_q) &&
		          ({2'b00, t_s1} <= {1'b0, lt_prev_q} + {10'd0, window_q});
		read_byte = pval_s1;
		if (psel_s1) begin
			read_byte[lgsp_pkg::HOLD_BIT]     = (hold_q != '0);
			read_byte[lgsp_pkg::NO_LIGHT_BIT] = !(in_cur || in_prev);
		end else begin
			read_byte[1] = pval_s1[0];
		end
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_q       <= '0;
			aim_third_q <= '0;
			button_q    <= 1'b0;
			hold_q      <= '0;
			lt_q        <= '0;
			lt_prev_q   <= '0;
			line_hit_q  <= 1'b0;
		end else if (fire) begin
			case (type_s1)
				lgsp_pkg::REQ_PIXEL: begin
					if (start_s1) begin
						lt_prev_q <= lt_base;
					end
					// take only the first lit pixel of a line
					if (!hit_eff && lit) begin
						lt_q       <= {1'b0, t_s1} + {10'd0, aim_third_q};
						line_hit_q <= 1'b1;
					end else begin
						lt_q <= lt_base;
						if (start_s1) begin
							line_hit_q <= 1'b0;
						end
					end
				end
				lgsp_pkg::REQ_POINTER: begin
					hold_q      <= (trig_s1 && !button_q) ? hold_cfg_q : hold_dec;
					aim_q.x     <= px_s1;
					aim_q.y     <= py_s1;
					aim_third_q <= third_prod[lgsp_pkg::DIV3_SHIFT +: lgsp_pkg::THIRD_W];
					button_q    <= trig_s1;
					if (px_s1[lgsp_pkg::PTR_W-1] || py_s1 >= lgsp_pkg::Y_OFF_SCREEN) begin
						lt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire && type_s1 == lgsp_pkg::REQ_READ) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && type_s1 == lgsp_pkg::REQ_READ) begin
			out_data_q <= read_byte;
		end
	end
endmodule

### sv/lgsp_pixel_judge.sv
`timescale 1ns / 1ps
// Lit-pixel test: aim window around the pointer and palette brightness threshold.
module lgsp_pixel_judge (
	input  lgsp_pkg::aim_t                aim,
	input  logic [lgsp_pkg::LINE_W-1:0]   line_number,
	input  logic [lgsp_pkg::COL_W-1:0]    pixel_column,
	input  logic [lgsp_pkg::BRIGHT_W-1:0] brightness,
	input  logic                          in_range,
	input  logic [lgsp_pkg::BRIGHT_W-1:0] threshold,
	output logic                          lit
);
	logic [lgsp_pkg::PTR_W-1:0]   row_lo;
	logic [lgsp_pkg::PTR_W:0]     row_hi;
	logic [lgsp_pkg::COL_W+1:0]   col_ext;
	logic [lgsp_pkg::COL_W+1:0]   x_ext;
	logic [lgsp_pkg::BRIGHT_W-1:0] bright_eff;
	logic                         row_ok;
	logic                         col_ok;

	// clip the row window at zero
	assign row_lo = (aim.y >= lgsp_pkg::ROW_REACH) ? aim.y - lgsp_pkg::ROW_REACH : '0;
	assign row_hi = {1'b0, aim.y} + {1'b0, lgsp_pkg::ROW_REACH};
	assign row_ok = (line_number >= row_lo) && ({1'b0, line_number} <= row_hi);

	assign col_ext = {2'b00, pixel_column};
	assign x_ext   = {1'b0, aim.x};
	assign col_ok  = (col_ext + lgsp_pkg::COL_LEFT >= x_ext) &&
	                 (col_ext <= x_ext + lgsp_pkg::COL_RIGHT);

	assign bright_eff = in_range ? brightness : '0;

	assign lit = !aim.x[lgsp_pkg::PTR_W-1] && row_ok && col_ok && (bright_eff >= threshold);
endmodule

### sv/lgsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the light gun sensor port, bound to the top level.
module lgsp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic [lgsp_pkg::TYPE_W-1:0]       req_type,
	input logic                              port_select,
	input logic [lgsp_pkg::BYTE_W-1:0]       port_value_in,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [lgsp_pkg::BYTE_W-1:0]       read_data
);
	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data))
		else $error("response changed while stalled");

	// a fresh response traces back to an accepted read request
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |->
			$past(req_valid && req_ready && req_type == lgsp_pkg::REQ_READ, 2))
		else $error("response without a read request");

	// untouched bits pass through from the request byte
	a_rsp_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |->
			read_data[7:5] == $past(port_value_in[7:5], 2) &&
			read_data[2] == $past(port_value_in[2], 2) &&
			read_data[0] == $past(port_value_in[0], 2))
		else $error("pass-through bits of port byte altered");

	// port 0 mirrors bit 0 into bit 1
	a_port0_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) && $past(!port_select, 2) |->
			read_data[1] == read_data[0] &&
			read_data[4:3] == $past(port_value_in[4:3], 2))
		else $error("port 0 byte wrong");
endmodule

bind light_gun_sensor_port lgsp_checker u_lgsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_type      (req.req_type),
	.port_select   (req.port_select),
	.port_value_in (req.port_value_in),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.read_data     (rsp.read_data)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the light gun sensor port: directed table, then random frames.
module tb_top;
	import lgsp_pkg::*;

	localparam int PAL_N       = PALETTE_ENTRIES_DEF;
	localparam int DIR_N       = 26;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 240;
	localparam int SETTLE      = 6;
	localparam int LIMIT       = 400000;
	localparam int LAST_LINE   = 261;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		req_type_t             kind;
		logic [LINE_W-1:0]     line;
		logic                  start;
		logic [COL_W-1:0]      col;
		logic [COLOR_W-1:0]    color;
		logic [CYCLE_W-1:0]    cyc;
		logic [PTR_W-1:0]      px;
		logic [PTR_W-1:0]      py;
		logic                  trig;
		logic                  port;
		logic [BYTE_W-1:0]     pval;
		logic [BRIGHT_W-1:0]   bright;
	} gun_req_t;

	typedef struct packed {
		gun_req_t          rq;
		logic              has_want;
		logic [BYTE_W-1:0] want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [BRIGHT_W-1:0]  cfg_data;

	lgsp_req_if req_ch ();
	lgsp_rsp_if rsp_ch ();

	light_gun_sensor_port i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// predicted state of the sensor
	logic [BRIGHT_W-1:0] thr_cfg;
	logic [WINDOW_W-1:0] win_cfg;
	logic [HOLD_W-1:0]   hold_cfg;
	logic [PTR_W-1:0]    aim_col;
	logic [PTR_W-1:0]    aim_row;
	logic                trig_prev;
	logic [HOLD_W-1:0]   hold_left;
	logic [TIME_W-1:0]   light_t;
	logic [TIME_W-1:0]   light_t_prev;
	logic                line_lit;
	logic [BRIGHT_W-1:0] pal_bright [PAL_N];
	bit   [PAL_N-1:0]    pal_written;
	int                  pal_used [$];

	logic [BYTE_W-1:0] port_bytes_q [$];

	int n_err      = 0;
	int n_items    = 0;
	int n_reads    = 0;
	int n_hits     = 0;
	int n_settings = 0;
	int idle_pct   = 0;
	int cycles     = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin : watchdog
		wait (cycles >= LIMIT);
		$display("Timeout after %0d cycles, %0d port bytes outstanding", cycles,
			port_bytes_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_err(input string what, input logic [BYTE_W-1:0] got,
			input logic [BYTE_W-1:0] want);
		$display("ERROR %0t: %s got %02h want %02h", $realtime, what, got, want);
		n_err++;
	endtask

	function automatic bit sees_light(int t, logic [TIME_W-1:0] start);
		return t >= int'(start) && t <= int'(start) + int'(win_cfg);
	endfunction

	task automatic predict_port(input gun_req_t r, output bit has_rsp,
			output logic [BYTE_W-1:0] data);
		int ax, ay, ln, col, row_lo;
		logic [BYTE_W-1:0] v;
		ax = int'(aim_col);
		ay = int'(aim_row);
		ln = int'(r.line);
		col = int'(r.col);
		v = r.pval;
		has_rsp = 1'b0;
		data = '0;
		case (r.kind)
		REQ_PIXEL: begin
			if (r.start) begin
				if (ln == 0)
					light_t = FRAME_TIME;
				light_t_prev = light_t;
				line_lit = 1'b0;
			end
			// row window clips at zero
			row_lo = (ay >= 3) ? ay - 3 : 0;
			if (!line_lit && ax < 256 && ln >= row_lo && ln <= ay + 3 &&
					col + 4 >= ax && col <= ax + 3 && pal_bright[r.color] >= thr_cfg) begin
				light_t = TIME_W'(int'(r.cyc) + ax / 3);
				line_lit = 1'b1;
				n_hits++;
			end
		end
		REQ_POINTER: begin
			if (hold_left != '0)
				hold_left = hold_left - 3'd1;
			if (r.trig && !trig_prev)
				hold_left = hold_cfg;
			aim_col = r.px;
			aim_row = r.py;
			trig_prev = r.trig;
			if (r.px >= 9'd256 || r.py >= Y_OFF_SCREEN)
				light_t = '0;
		end
		REQ_READ: begin
			if (r.port) begin
				v[HOLD_BIT] = hold_left != '0;
				v[NO_LIGHT_BIT] = !(sees_light(int'(r.cyc), light_t_prev) ||
					sees_light(int'(r.cyc), light_t));
			end else begin
				v[1] = v[0];
			end
			has_rsp = 1'b1;
			data = v;
		end
		default: begin
			pal_bright[r.color] = r.bright;
			if (!pal_written[r.color]) begin
				pal_written[r.color] = 1'b1;
				pal_used.push_back(int'(r.color));
			end
		end
		endcase
	endtask

	// pixels only index loaded palette entries
	function automatic logic [COLOR_W-1:0] pick_color();
		if (pal_used.size() == 0)
			return '0;
		return COLOR_W'(pal_used[$urandom_range(0, pal_used.size() - 1)]);
	endfunction

	function automatic logic [BRIGHT_W-1:0] pick_bright();
		int b;
		case ($urandom_range(0, 3))
		0: b = 765;
		1: b = int'(thr_cfg) - 2 + int'($urandom_range(0, 4));
		default: b = int'($urandom_range(0, 765));
		endcase
		if (b < 0)
			b = 0;
		if (b > 765)
			b = 765;
		return BRIGHT_W'(b);
	endfunction

	function automatic gun_req_t rand_req();
		gun_req_t r;
		r.kind   = req_type_t'($urandom_range(0, 3));
		r.line   = LINE_W'($urandom_range(0, LAST_LINE));
		r.start  = 1'($urandom_range(0, 1));
		r.col    = COL_W'($urandom_range(0, 255));
		r.color  = pick_color();
		r.cyc    = CYCLE_W'($urandom_range(0, 65535));
		r.px     = PTR_W'($urandom_range(0, 511));
		r.py     = PTR_W'($urandom_range(0, 511));
		r.trig   = 1'($urandom_range(0, 1));
		r.port   = 1'($urandom_range(0, 1));
		r.pval   = BYTE_W'($urandom_range(0, 255));
		r.bright = pick_bright();
		if (r.kind == REQ_PAL_LOAD)
			r.color = COLOR_W'($urandom_range(0, PAL_N - 1));
		return r;
	endfunction

	function automatic dir_row_t row_pix(int ln, bit st, int col, int color, int cyc);
		dir_row_t d;
		d = '0;
		d.rq.kind  = REQ_PIXEL;
		d.rq.line  = LINE_W'(ln);
		d.rq.start = st;
		d.rq.col   = COL_W'(col);
		d.rq.color = COLOR_W'(color);
		d.rq.cyc   = CYCLE_W'(cyc);
		return d;
	endfunction

	function automatic dir_row_t row_ptr(int x, int y, bit trig);
		dir_row_t d;
		d = '0;
		d.rq.kind = REQ_POINTER;
		d.rq.px   = PTR_W'(x);
		d.rq.py   = PTR_W'(y);
		d.rq.trig = trig;
		return d;
	endfunction

	function automatic dir_row_t row_pal(int idx, int br);
		dir_row_t d;
		d = '0;
		d.rq.kind   = REQ_PAL_LOAD;
		d.rq.color  = COLOR_W'(idx);
		d.rq.bright = BRIGHT_W'(br);
		return d;
	endfunction

	function automatic dir_row_t row_read(bit port, int val, int cyc, bit has_want, int want);
		dir_row_t d;
		d = '0;
		d.rq.kind    = REQ_READ;
		d.rq.port    = port;
		d.rq.pval    = BYTE_W'(val);
		d.rq.cyc     = CYCLE_W'(cyc);
		d.has_want   = has_want;
		d.want       = BYTE_W'(want);
		return d;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input gun_req_t r, input bit has_want,
			input logic [BYTE_W-1:0] want);
		bit has_rsp;
		logic [BYTE_W-1:0] pdata;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= r.kind;
		req_ch.line_number    <= r.line;
		req_ch.line_start     <= r.start;
		req_ch.pixel_column   <= r.col;
		req_ch.pixel_color    <= r.color;
		req_ch.cycle_time     <= r.cyc;
		req_ch.pointer_x      <= r.px;
		req_ch.pointer_y      <= r.py;
		req_ch.trigger        <= r.trig;
		req_ch.port_select    <= r.port;
		req_ch.port_value_in  <= r.pval;
		req_ch.brightness_sum <= r.bright;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_port(r, has_rsp, pdata);
		if (has_rsp)
			port_bytes_q.push_back(has_want ? want : pdata);
		n_items++;
		@(negedge clk);
	endtask

	// hold the request channel until every port byte is back and the pipe is empty
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (port_bytes_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_config(input int thr, input int win, input int hold);
		cfg_wen  <= 1'b1;
		cfg_idx  <= CFG_THRESHOLD;
		cfg_data <= BRIGHT_W'(thr);
		@(negedge clk);
		cfg_idx  <= CFG_WINDOW;
		cfg_data <= BRIGHT_W'(win);
		@(negedge clk);
		cfg_idx  <= CFG_HOLD;
		cfg_data <= BRIGHT_W'(hold);
		@(negedge clk);
		// an index past the register list must change nothing
		cfg_idx  <= CFG_UNUSED;
		cfg_data <= BRIGHT_W'($urandom_range(0, 1023));
		@(negedge clk);
		cfg_wen  <= 1'b0;
		thr_cfg  = BRIGHT_W'(thr);
		win_cfg  = WINDOW_W'(win);
		hold_cfg = HOLD_W'(hold);
		n_settings++;
		@(negedge clk);
	endtask

	// one frame: optional palette load, aim update, scanlines around the aim point, reads mostly near the light time
	task automatic run_frame();
		gun_req_t r;
		int ax, ay, base, nl, np, nr, ln, t, ref_t;
		if ($urandom_range(0, 3) == 0) begin
			r = rand_req();
			r.kind = REQ_PAL_LOAD;
			r.color = COLOR_W'($urandom_range(0, PAL_N - 1));
			send_req(r, 1'b0, '0);
		end
		case ($urandom_range(0, 9))
		0: begin
			ax = int'($urandom_range(0, 511));
			ay = int'($urandom_range(0, 511));
		end
		1: begin
			ax = int'($urandom_range(0, 255));
			ay = int'($urandom_range(240, 264));
		end
		default: begin
			ax = int'($urandom_range(0, 255));
			ay = int'($urandom_range(0, 239));
		end
		endcase
		r = rand_req();
		r.kind = REQ_POINTER;
		r.px = PTR_W'(ax);
		r.py = PTR_W'(ay);
		r.trig = $urandom_range(0, 9) < 6;
		send_req(r, 1'b0, '0);
		base = int'($urandom_range(0, 65535));
		if ($urandom_range(0, 4) == 0) begin
			r = rand_req();
			r.kind = REQ_PIXEL;
			r.line = '0;
			r.start = 1'b1;
			send_req(r, 1'b0, '0);
		end
		nl = int'($urandom_range(1, 4));
		for (int i = 0; i < nl; i++) begin
			ln = ay - 3 + int'($urandom_range(0, 6));
			if (ay > LAST_LINE + 3)
				ln = int'($urandom_range(0, LAST_LINE));
			if (ln < 0)
				ln = 0;
			if (ln > LAST_LINE)
				ln = LAST_LINE;
			np = int'($urandom_range(1, 5));
			for (int j = 0; j < np; j++) begin
				r = rand_req();
				r.kind = REQ_PIXEL;
				r.line = LINE_W'(ln);
				// drop the line start now and then
				r.start = (j == 0) && ($urandom_range(0, 9) != 0);
				t = ax - 5 + int'($urandom_range(0, 9));
				if (ax > 255)
					t = int'($urandom_range(0, 255));
				if (t < 0)
					t = 0;
				if (t > 255)
					t = 255;
				r.col = COL_W'(t);
				r.cyc = CYCLE_W'(base + ln * 114 + j * 3);
				send_req(r, 1'b0, '0);
			end
		end
		nr = int'($urandom_range(1, 3));
		for (int i = 0; i < nr; i++) begin
			r = rand_req();
			r.kind = REQ_READ;
			r.port = $urandom_range(0, 4) != 0;
			if ($urandom_range(0, 4) != 0) begin
				ref_t = $urandom_range(0, 1) ? int'(light_t) : int'(light_t_prev);
				t = ref_t - 3 + int'($urandom_range(0, int'(win_cfg) + 6));
				if (t < 0)
					t = 0;
				if (t > 65535)
					t = 65535;
				r.cyc = CYCLE_W'(t);
			end
			send_req(r, 1'b0, '0);
		end
	endtask

	task automatic run_noise();
		int n;
		n = int'($urandom_range(1, 4));
		repeat (n) send_req(rand_req(), 1'b0, '0);
	endtask

	initial begin : rsp_stall
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && idle_pct != 0 && $urandom_range(0, 299) < idle_pct)
				stall = int'($urandom_range(1, 11));
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		logic [BYTE_W-1:0] w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (port_bytes_q.size() == 0) begin
				report_err("response with no read pending", rsp_ch.read_data, '0);
			end else begin
				w = port_bytes_q.pop_front();
				n_reads++;
				if (rsp_ch.read_data !== w)
					report_err("read_data", rsp_ch.read_data, w);
			end
		end
	end

	initial begin : stimulus
		dir_row_t dir_tab [DIR_N];
		int phase_end;
		arst_n                = 1'b0;
		cfg_wen               = 1'b0;
		cfg_idx               = '0;
		cfg_data              = '0;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = '0;
		req_ch.line_number    = '0;
		req_ch.line_start     = 1'b0;
		req_ch.pixel_column   = '0;
		req_ch.pixel_color    = '0;
		req_ch.cycle_time     = '0;
		req_ch.pointer_x      = '0;
		req_ch.pointer_y      = '0;
		req_ch.trigger        = 1'b0;
		req_ch.port_select    = 1'b0;
		req_ch.port_value_in  = '0;
		req_ch.brightness_sum = '0;
		thr_cfg      = THRESHOLD_RST;
		win_cfg      = WINDOW_RST;
		hold_cfg     = HOLD_RST;
		aim_col      = '0;
		aim_row      = '0;
		trig_prev    = 1'b0;
		hold_left    = '0;
		light_t      = '0;
		light_t_prev = '0;
		line_lit     = 1'b0;
		pal_written  = '0;
		idle_pct     = 20;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		dir_tab = '{
			row_pal(0, 765),
			row_pal(1, 300),
			row_pal(2, 299),
			row_pal(63, 0),
			row_read(1'b1, 'hFF, 0, 1'b1, 'hE7),
			row_read(1'b1, 'h00, 11, 1'b1, 'h08),
			row_read(1'b1, 'h18, 10, 1'b1, 'h00),
			row_read(1'b0, 'h01, 0, 1'b1, 'h03),
			row_read(1'b0, 'hFE, 0, 1'b1, 'hFC),
			row_ptr(0, 0, 1'b1),
			row_read(1'b1, 'hFF, 0, 1'b0, 0),
			row_pix(0, 1'b1, 0, 0, 100),
			row_read(1'b1, 'h00, 110, 1'b0, 0),
			row_ptr(255, 239, 1'b0),
			row_ptr(256, 0, 1'b1),
			row_pix(1, 1'b1, 255, 0, 500),
			row_ptr(100, 2, 1'b1),
			row_pix(5, 1'b1, 96, 1, 200),
			row_pix(5, 1'b0, 103, 0, 300),
			row_read(1'b1, 'h00, 243, 1'b0, 0),
			row_read(1'b1, 'h00, 244, 1'b0, 0),
			row_pix(6, 1'b1, 103, 2, 400),
			row_pix(4, 1'b1, 97, 63, 401),
			row_ptr(10, 250, 1'b1),
			row_pix(253, 1'b1, 13, 0, 65535),
			row_read(1'b1, 'hFF, 65535, 1'b0, 0)
		};
		foreach (dir_tab[i])
			send_req(dir_tab[i].rq, dir_tab[i].has_want, dir_tab[i].want);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: set_config(0, 0, 0);
			1: set_config(765, 255, 7);
			PHASES - 1: set_config(THRESHOLD_RST, WINDOW_RST, HOLD_RST);
			default: set_config($urandom_range(0, 765), $urandom_range(0, 255),
				$urandom_range(0, 7));
			endcase
			// no idling in the last phase, and none in some others
			idle_pct = (p == PHASES - 1 || p % 3 == 1) ? 0 : 10 + 10 * (p % 3);
			phase_end = n_items + PHASE_ITEMS;
			while (n_items < phase_end) begin
				if ($urandom_range(0, 9) < 8)
					run_frame();
				else
					run_noise();
				if ($urandom_range(0, 59) == 0)
					drain();
			end
			drain();
		end

		$display("Sent %0d requests under %0d register settings", n_items, n_settings + 1);
		$display("Checked %0d port reads; %0d scanline light hits predicted", n_reads, n_hits);
		if (n_err == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### light_gun_sensor_port.f
sv/lgsp_pkg.sv
sv/lgsp_req_if.sv
sv/lgsp_rsp_if.sv
sv/lgsp_pixel_judge.sv
sv/light_gun_sensor_port.sv
sv/lgsp_checker.sv
tb/tb_top.sv
